// ===== hdl/psra_pkg.sv =====
// ----------------------------------------------------------------------------
// psra_pkg
// Shared types and constants of the power sample ring averager.
// ----------------------------------------------------------------------------
package psra_pkg;

	localparam int TIME_W      = 32;
	localparam int VOLT_W      = 15;
	localparam int CUR_W       = 16;
	localparam int CNT_OUT_W   = 5;
	localparam int INTERVAL_W  = 16;
	localparam int ENTRY_W     = TIME_W + VOLT_W + CUR_W;
	localparam int S_TDATA_W   = 64;
	localparam int M_TDATA_W   = 104;
	localparam int TUSER_W     = 2;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam int RING_DEPTH_DEFAULT = 16;

	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;

	// register index, taken from paddr[2]
	localparam logic REG_UPDATE_INTERVAL = 1'b0;

	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_CAPTURE = 2'd1,
		KIND_AVERAGE = 2'd2,
		KIND_AVG_ALT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DRAIN,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/psra_ram.sv =====
// ----------------------------------------------------------------------------
// psra_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module psra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== hdl/power_sample_ring_averager.sv =====
// ----------------------------------------------------------------------------
// power_sample_ring_averager
// Ring of timestamped voltage/current readings with rate-limited capture
// and a mean over all stored entries.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction per item, kind in s_tuser. Kind 0 stores
// the reading, kind 1 stores it only if more than update_interval_ms has
// passed since the last capture, kinds 2 and 3 ask for the mean of the ring.
// Output stream m_*: exactly one result transaction per input transaction.
// Sample or capture results are registered in the cycle after the input
// transaction. An average reads the RAM once per entry, then runs a restoring
// divider that resolves one quotient bit per cycle. One item is worked on at
// a time; the next is taken once the result sits in the output register.
// The ring RAM needs no clearing: entries are always filled from slot one
// upward, so a fill count tells which ones hold data.
// Reset empties the ring, sets the newest slot and last capture time to zero
// and update_interval_ms to 1000. A stalled receiver holds the result in the
// output register, and s_tready stays low until it drains.
// Config: APB register 0 (byte address 0) is update_interval_ms; the user must
// write it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module power_sample_ring_averager
	import psra_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// input stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // now_ms[31:0], bus_voltage_mv[46:32],
	                                        // load_current_ma[62:47], zero[63]
	input  logic [TUSER_W-1:0]    s_tuser,  // kind[1:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,  // reading_time_ms[31:0],
	                                        // reading_voltage_mv[46:32],
	                                        // reading_current_ma[62:47],
	                                        // avg_voltage_mv[77:63],
	                                        // avg_current_ma[93:78],
	                                        // valid_count[98:94], zero[103:99]
	output logic [TUSER_W-1:0]    m_tuser,  // captured[0], avg_valid[1]
	// APB config
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int ADDR_W = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(RING_DEPTH + 1);
	localparam int DIV_W  = VOLT_W + CNT_W;
	localparam int CSUM_W = CUR_W + CNT_W;
	localparam int STEP_W = $clog2(DIV_W);

	// ---------------- config ----------------
	logic [INTERVAL_W-1:0] interval_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_UPDATE_INTERVAL) begin
			interval_q <= pwdata[INTERVAL_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_UPDATE_INTERVAL) begin
			prdata = {{(APB_DATA_W-INTERVAL_W){1'b0}}, interval_q};
		end
	end

	// ---------------- input fields ----------------
	kind_t                    in_kind;
	logic [TIME_W-1:0]        in_time;
	logic [VOLT_W-1:0]        in_volt;
	logic [CUR_W-1:0]         in_cur;

	assign in_kind = kind_t'(s_tuser);
	assign in_time = s_tdata[TIME_W-1:0];
	assign in_volt = s_tdata[TIME_W+VOLT_W-1:TIME_W];
	assign in_cur  = s_tdata[ENTRY_W-1:TIME_W+VOLT_W];

	// ---------------- state ----------------
	state_t                   state_q, state_d;
	logic [ADDR_W-1:0]        slot_q;
	logic [CNT_W-1:0]         fill_q;
	logic [TIME_W-1:0]        last_cap_q;
	logic [TIME_W-1:0]        newest_time_q;
	logic [VOLT_W-1:0]        newest_volt_q;
	logic [CUR_W-1:0]         newest_cur_q;

	logic [ADDR_W-1:0]        addr_q;
	logic                     acc_en_s1;
	logic [DIV_W-1:0]         vsum_q;
	logic signed [CSUM_W-1:0] csum_q;

	logic [DIV_W-1:0]         vq_q, cq_q;
	logic [CNT_W-1:0]         vr_q, cr_q;
	logic                     cneg_q;
	logic [STEP_W-1:0]        step_q;

	logic                     out_valid_q;
	logic [TIME_W-1:0]        out_time_q;
	logic [VOLT_W-1:0]        out_volt_q;
	logic [CUR_W-1:0]         out_cur_q;
	logic                     out_cap_q;
	logic [VOLT_W-1:0]        out_avgv_q;
	logic [CUR_W-1:0]         out_avgc_q;
	logic [CNT_OUT_W-1:0]     out_cnt_q;
	logic                     out_avgok_q;

	// ---------------- datapath helpers ----------------
	logic                     out_free;
	logic                     in_fire;
	logic                     is_store;
	logic                     window_open;
	logic [ADDR_W-1:0]        next_slot;
	logic                     fill_full;
	logic                     entry_ok;
	logic                     last_addr;
	logic                     div_last;

	logic                     ram_en, ram_we;
	logic [ADDR_W-1:0]        ram_addr;
	logic [ENTRY_W-1:0]       ram_rdata;
	logic [VOLT_W-1:0]        rd_volt;
	logic signed [CUR_W-1:0]  rd_cur;

	logic [CSUM_W-1:0]        cmag;
	logic [CNT_W:0]           vtrial, ctrial;
	logic                     vbit, cbit;
	logic [CUR_W-1:0]         cq_trunc;

	assign out_free    = !out_valid_q || m_tready;
	assign in_fire     = s_tvalid && s_tready;
	assign window_open = (in_time - last_cap_q) > {{(TIME_W-INTERVAL_W){1'b0}}, interval_q};
	assign is_store    = (in_kind == KIND_SAMPLE) || (in_kind == KIND_CAPTURE && window_open);
	assign next_slot   = (slot_q == ADDR_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
	assign fill_full   = fill_q == CNT_W'(RING_DEPTH);
	// slots are filled from one upward, wrapping to zero last
	assign entry_ok    = fill_full || (addr_q != '0 && CNT_W'(addr_q) <= fill_q);
	assign last_addr   = addr_q == ADDR_W'(RING_DEPTH - 1);
	assign div_last    = step_q == STEP_W'(DIV_W - 1);

	assign rd_volt = ram_rdata[TIME_W+VOLT_W-1:TIME_W];
	assign rd_cur  = ram_rdata[ENTRY_W-1:TIME_W+VOLT_W];

	assign cmag = csum_q[CSUM_W-1] ? (~csum_q + 1'b1) : csum_q;

	// one restoring step for each dividend
	assign vtrial = {vr_q, vq_q[DIV_W-1]};
	assign ctrial = {cr_q, cq_q[DIV_W-1]};
	assign vbit   = vtrial >= {1'b0, fill_q};
	assign cbit   = ctrial >= {1'b0, fill_q};

	assign cq_trunc = cq_q[CUR_W-1:0];

	psra_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({in_cur, in_volt, in_time}),
		.rdata(ram_rdata)
	);

	// ---------------- FSM ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && in_kind != KIND_SAMPLE && in_kind != KIND_CAPTURE) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: begin
				if (last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_LOAD;
			ST_LOAD: begin
				state_d = (fill_q == '0) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		ram_en   = 1'b0;
		ram_we   = 1'b0;
		ram_addr = addr_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = out_free;
				ram_we   = in_fire && is_store;
				ram_en   = ram_we;
				ram_addr = next_slot;
			end
			ST_SUM: begin
				ram_en = 1'b1;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			slot_q        <= '0;
			fill_q        <= '0;
			last_cap_q    <= '0;
			newest_time_q <= '0;
			newest_volt_q <= '0;
			newest_cur_q  <= '0;
			addr_q        <= '0;
			acc_en_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			acc_en_s1 <= (state_q == ST_SUM) && entry_ok;

			if (state_q == ST_SUM) begin
				addr_q <= addr_q + 1'b1;
			end else begin
				addr_q <= '0;
			end

			if (state_q == ST_IDLE && in_fire && is_store) begin
				slot_q        <= next_slot;
				newest_time_q <= in_time;
				newest_volt_q <= in_volt;
				newest_cur_q  <= in_cur;
				if (!fill_full) begin
					fill_q <= fill_q + 1'b1;
				end
				if (in_kind == KIND_CAPTURE) begin
					last_cap_q <= in_time;
				end
			end

			if ((state_q == ST_IDLE && in_fire && (in_kind == KIND_SAMPLE ||
			     in_kind == KIND_CAPTURE)) || (state_q == ST_DONE && out_free)) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------- sums and divider ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			vsum_q <= '0;
			csum_q <= '0;
		end else if (acc_en_s1) begin
			vsum_q <= vsum_q + DIV_W'(rd_volt);
			csum_q <= csum_q + CSUM_W'(rd_cur);
		end

		if (state_q == ST_LOAD) begin
			vq_q   <= vsum_q;
			cq_q   <= DIV_W'(cmag);
			vr_q   <= '0;
			cr_q   <= '0;
			cneg_q <= csum_q[CSUM_W-1];
			step_q <= '0;
		end else if (state_q == ST_DIV) begin
			vq_q   <= {vq_q[DIV_W-2:0], vbit};
			cq_q   <= {cq_q[DIV_W-2:0], cbit};
			vr_q   <= vbit ? CNT_W'(vtrial - {1'b0, fill_q}) : CNT_W'(vtrial);
			cr_q   <= cbit ? CNT_W'(ctrial - {1'b0, fill_q}) : CNT_W'(ctrial);
			step_q <= step_q + 1'b1;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire) begin
			out_cap_q   <= is_store;
			out_avgv_q  <= '0;
			out_avgc_q  <= '0;
			out_cnt_q   <= '0;
			out_avgok_q <= 1'b0;
			if (is_store) begin
				out_time_q <= in_time;
				out_volt_q <= in_volt;
				out_cur_q  <= in_cur;
			end else begin
				out_time_q <= newest_time_q;
				out_volt_q <= newest_volt_q;
				out_cur_q  <= newest_cur_q;
			end
		end else if (state_q == ST_DONE && out_free) begin
			out_time_q  <= newest_time_q;
			out_volt_q  <= newest_volt_q;
			out_cur_q   <= newest_cur_q;
			out_cap_q   <= 1'b0;
			out_cnt_q   <= CNT_OUT_W'(fill_q);
			out_avgok_q <= fill_q != '0;
			if (fill_q != '0) begin
				out_avgv_q <= vq_q[VOLT_W-1:0];
				out_avgc_q <= cneg_q ? (~cq_trunc + 1'b1) : cq_trunc;
			end else begin
				out_avgv_q <= '0;
				out_avgc_q <= '0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - ENTRY_W - VOLT_W - CUR_W - CNT_OUT_W){1'b0}},
	                   out_cnt_q, out_avgc_q, out_avgv_q,
	                   out_cur_q, out_volt_q, out_time_q};
	assign m_tuser  = {out_avgok_q, out_cap_q};

endmodule

// ===== bench/psra_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// psra_checker
// Watches the input, result and register channels of the power sample ring
// averager. It keeps its own copy of the ring and the capture interval, works
// out the result of every accepted item and compares each result transaction,
// field by field, with the oldest one still owed.
// ----------------------------------------------------------------------------
module psra_checker
	import psra_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // now_ms, bus_voltage_mv, load_current_ma
	input  logic [TUSER_W-1:0]    s_tuser,  // kind
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,  // reading time/voltage/current,
	                                        // avg voltage/current, valid_count
	input  logic [TUSER_W-1:0]    m_tuser,  // captured, avg_valid
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  pready,
	output int                    mismatch_count,
	output int                    results_owed
);

	localparam int VOLT_LSB  = TIME_W;
	localparam int CUR_LSB   = TIME_W + VOLT_W;
	localparam int AVG_V_LSB = ENTRY_W;
	localparam int AVG_C_LSB = ENTRY_W + VOLT_W;
	localparam int CNT_LSB   = AVG_C_LSB + CUR_W;

	typedef struct {
		logic [TIME_W-1:0]       t_ms;
		logic [VOLT_W-1:0]       volt_mv;
		logic signed [CUR_W-1:0] cur_ma;
		logic                    captured;
		logic [VOLT_W-1:0]       avg_volt_mv;
		logic signed [CUR_W-1:0] avg_cur_ma;
		logic [CNT_OUT_W-1:0]    entry_count;
		logic                    avg_valid;
	} reading_result_t;

	logic [TIME_W-1:0]       ring_time [RING_DEPTH];
	logic [VOLT_W-1:0]       ring_volt [RING_DEPTH];
	logic signed [CUR_W-1:0] ring_cur  [RING_DEPTH];
	logic                    ring_ok   [RING_DEPTH];
	int                      newest;
	logic [TIME_W-1:0]       last_capture_ms;
	logic [INTERVAL_W-1:0]   interval_ms;

	reading_result_t awaited_results [$];

	function automatic void store_reading(input logic [TIME_W-1:0] now,
			input logic [VOLT_W-1:0] volt, input logic signed [CUR_W-1:0] cur);
		newest = (newest + 1) % RING_DEPTH;
		ring_time[newest] = now;
		ring_volt[newest] = volt;
		ring_cur[newest]  = cur;
		ring_ok[newest]   = 1'b1;
	endfunction

	function automatic reading_result_t ring_result(input kind_t kind,
			input logic [TIME_W-1:0] now, input logic [VOLT_W-1:0] volt,
			input logic signed [CUR_W-1:0] cur);
		reading_result_t r;
		logic [TIME_W-1:0] gap;
		longint unsigned vsum;
		longint csum;
		int cnt;
		r = '{default: '0};
		vsum = 0;
		csum = 0;
		cnt = 0;
		case (kind)
			KIND_SAMPLE: begin
				store_reading(now, volt, cur);
				r.captured = 1'b1;
			end
			KIND_CAPTURE: begin
				// elapsed time is taken modulo 2^32, so a wrapped clock still counts
				gap = now - last_capture_ms;
				if (gap > {{(TIME_W-INTERVAL_W){1'b0}}, interval_ms}) begin
					store_reading(now, volt, cur);
					last_capture_ms = now;
					r.captured = 1'b1;
				end
			end
			default: begin
				foreach (ring_ok[j]) begin
					if (ring_ok[j]) begin
						vsum += ring_volt[j];
						csum += ring_cur[j];
						cnt++;
					end
				end
				if (cnt != 0) begin
					r.avg_volt_mv = VOLT_W'(vsum / cnt);
					r.avg_cur_ma  = CUR_W'(csum / longint'(cnt));  // truncates toward zero
					r.avg_valid   = 1'b1;
				end
				r.entry_count = CNT_OUT_W'(cnt);
			end
		endcase
		if (ring_ok[newest]) begin
			r.t_ms    = ring_time[newest];
			r.volt_mv = ring_volt[newest];
			r.cur_ma  = ring_cur[newest];
		end
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reading_result_t oldest;
		logic signed [CUR_W-1:0] got_cur;
		logic signed [CUR_W-1:0] got_avg_cur;
		if (!arst_n) begin
			foreach (ring_ok[j]) ring_ok[j] = 1'b0;
			newest = 0;
			last_capture_ms = '0;
			interval_ms = INTERVAL_RESET;
			awaited_results.delete();
			mismatch_count = 0;
			results_owed = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_UPDATE_INTERVAL)
				interval_ms = pwdata[INTERVAL_W-1:0];
			// retire the result before queueing a new item: a result can never
			// belong to an item accepted at the same edge
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					$error("result transaction with no item outstanding");
					mismatch_count++;
				end else begin
					oldest = awaited_results.pop_front();
					got_cur = m_tdata[CUR_LSB +: CUR_W];
					got_avg_cur = m_tdata[AVG_C_LSB +: CUR_W];
					check_field("reading_time_ms", oldest.t_ms, m_tdata[0 +: TIME_W]);
					check_field("reading_voltage_mv", oldest.volt_mv,
						m_tdata[VOLT_LSB +: VOLT_W]);
					check_field("reading_current_ma", oldest.cur_ma, got_cur);
					check_field("captured", oldest.captured, m_tuser[0]);
					check_field("avg_voltage_mv", oldest.avg_volt_mv,
						m_tdata[AVG_V_LSB +: VOLT_W]);
					check_field("avg_current_ma", oldest.avg_cur_ma, got_avg_cur);
					check_field("valid_count", oldest.entry_count,
						m_tdata[CNT_LSB +: CNT_OUT_W]);
					check_field("avg_valid", oldest.avg_valid, m_tuser[1]);
				end
			end
			if (s_tvalid && s_tready)
				awaited_results.push_back(ring_result(kind_t'(s_tuser),
					s_tdata[0 +: TIME_W], s_tdata[VOLT_LSB +: VOLT_W],
					s_tdata[CUR_LSB +: CUR_W]));
			results_owed = awaited_results.size();
		end
	end

endmodule

// ===== bench/tb_power_sample_ring_averager.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_power_sample_ring_averager
// Drives the ring averager with directed and random sample, capture and
// average items under varying interval settings and stall patterns; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_power_sample_ring_averager;
	import psra_pkg::*;

	localparam logic [APB_ADDR_W-1:0] INTERVAL_ADDR   = {REG_UPDATE_INTERVAL, 2'b00};
	localparam logic [APB_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;
	localparam int END_WAIT       = 48;    // longer than one average
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 5000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;  // now_ms[31:0], bus_voltage_mv[46:32],
	                                      // load_current_ma[62:47], zero[63]
	logic [TUSER_W-1:0]    s_tuser = '0;  // kind[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;       // reading_time_ms, reading_voltage_mv,
	                                      // reading_current_ma, avg_voltage_mv,
	                                      // avg_current_ma, valid_count, zero
	logic [TUSER_W-1:0]    m_tuser;       // captured[0], avg_valid[1]
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	int          mismatch_count;
	int          results_owed;
	int          tx_idle_pct = 27;
	int          rx_idle_pct = 69;
	bit          hold_req = 1'b0;
	int          stall_cycles = 0;
	int unsigned interval_ms = 1000;
	logic [TIME_W-1:0] clock_ms = '0;

	power_sample_ring_averager DUT (.*);

	psra_checker checker_i (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random back-pressure, plus one long hold on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(input kind_t kind, input logic [TIME_W-1:0] now,
			input logic [VOLT_W-1:0] volt, input logic [CUR_W-1:0] cur);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, cur, volt, now};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_interval(input int unsigned ival);
		interval_ms = ival;
		// upper bits are junk on purpose, the register keeps 16 bits
		apb_write(INTERVAL_ADDR, {16'($urandom), 16'(ival)});
	endtask

	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
		repeat (END_WAIT) @(posedge clk);
	endtask

	task automatic send_random(input int n);
		int r;
		kind_t kind;
		logic [VOLT_W-1:0] volt;
		logic [CUR_W-1:0] cur;
		repeat (n) begin
			// mostly steps around the interval so captures both pass and miss
			r = $urandom_range(99);
			if (r < 70)
				clock_ms += $urandom_range(2 * interval_ms + 2);
			else if (r < 95)
				clock_ms += $urandom_range(3);
			else
				clock_ms = $urandom;
			r = $urandom_range(99);
			kind = r < 40 ? KIND_SAMPLE : r < 80 ? KIND_CAPTURE :
				r < 92 ? KIND_AVERAGE : KIND_AVG_ALT;
			if ($urandom_range(9) == 0)
				volt = $urandom_range(1) ? '1 : '0;
			else
				volt = VOLT_W'($urandom);
			if ($urandom_range(9) == 0)
				cur = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
			else
				cur = CUR_W'($urandom);
			send_item(kind, clock_ms, volt, cur);
		end
	endtask

	initial begin
		int phase;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring, both average codes
		send_item(KIND_AVERAGE, 32'd5, 15'd0, 16'h0000);
		send_item(KIND_AVG_ALT, 32'd6, 15'h7FFF, 16'h8000);
		// reset interval 1000, last capture at 0: no reading stored yet
		send_item(KIND_CAPTURE, 32'd0, 15'd10, 16'h000A);
		send_item(KIND_CAPTURE, 32'd1000, 15'd20, 16'h0014);  // gap equals interval
		send_item(KIND_CAPTURE, 32'd1001, 15'h7FFF, 16'h8000);
		send_item(KIND_SAMPLE, 32'hFFFF_FFFF, 15'd0, 16'h7FFF);
		send_item(KIND_AVERAGE, 32'd0, 15'd0, 16'h0000);
		send_item(KIND_CAPTURE, 32'd2001, 15'd3, 16'h0003);
		send_item(KIND_CAPTURE, 32'd2002, 15'd1, 16'hFFFF);
		// enough samples to wrap the ring and overwrite the oldest slots
		for (int i = 0; i < 14; i++)
			send_item(KIND_SAMPLE, $urandom, i[0] ? 15'h7FFF : VOLT_W'($urandom),
				i[1] ? 16'h8000 : CUR_W'($urandom));
		send_item(KIND_AVG_ALT, 32'd0, 15'd0, 16'h0000);
		wait_results_done();

		// zero interval: equal timestamps never capture, a wrapped clock does
		set_interval(0);
		send_item(KIND_CAPTURE, 32'hFFFF_FFF0, 15'd100, 16'hFF00);
		send_item(KIND_CAPTURE, 32'hFFFF_FFF0, 15'd200, 16'h0100);
		send_item(KIND_CAPTURE, 32'd5, 15'd300, 16'h8001);
		wait_results_done();
		set_interval(32'h0000_FFFF);
		apb_write(UNUSED_REG_ADDR, 32'hFFFF_FFFF);  // no such register
		send_item(KIND_CAPTURE, 32'd5 + 32'd65535, 15'd400, 16'h7FFE);
		send_item(KIND_CAPTURE, 32'd5 + 32'd65536, 15'd500, 16'hFFFE);
		send_item(KIND_AVERAGE, 32'd0, 15'd0, 16'h0000);
		wait_results_done();

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 27;
					rx_idle_pct = 69;
					set_interval($urandom_range(65535));
					send_random(580);
				end
				1: begin
					tx_idle_pct = 69;
					rx_idle_pct = 27;
					set_interval($urandom_range(300));
					send_random(580);
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					set_interval(1000);
					send_random(200);
					hold_req = 1'b1;   // block fills and stalls while items keep coming
					send_random(100);
					wait_results_done();
					send_random(280);
				end
			endcase
			wait_results_done();
		end

		if (mismatch_count == 0 && results_owed == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
